FILE: rtl/core/cltok_pkg.sv
// Types, codes and lookup functions shared by the tokenizer core.
// Holds the keyword and operator tables used for token typing.
// Depends on nothing.
package cltok_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM_DIGIT,
        MODE_NUM_DOT,
        MODE_WORD,
        MODE_STRING,
        MODE_OPER
    } mode_t;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_UNCLOSED = 2'd0;
    localparam logic [1:0] ERR_BAD_END  = 2'd1;
    localparam logic [1:0] ERR_DOT      = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

    localparam logic [5:0] TYPE_OP_BASE = 6'd16;
    localparam logic [5:0] TYPE_INT     = 6'd56;
    localparam logic [5:0] TYPE_FLOAT   = 6'd57;
    localparam logic [5:0] TYPE_IDENT   = 6'd58;
    localparam logic [5:0] TYPE_STRING  = 6'd59;
    localparam logic [5:0] OP_NONE      = 6'd40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [5:0]  ttype;
        logic [15:0] line;
        logic [11:0] col;
        logic [1:0]  ecode;
        logic        last;
    } result_t;

    // key holds the first eight bytes, first byte highest, unused bytes zero
    function automatic logic [5:0] kw_type(input logic [63:0] key, input logic [3:0] len);
        logic [5:0] t;
        t = TYPE_IDENT;
        if (len <= 4'd8)
        begin
            case (key)
                {"bool", 32'h0}:     t = 6'd0;
                {"break", 24'h0}:    t = 6'd1;
                {"char", 32'h0}:     t = 6'd2;
                "continue":          t = 6'd3;
                {"do", 48'h0}:       t = 6'd4;
                {"else", 32'h0}:     t = 6'd5;
                {"false", 24'h0}:    t = 6'd6;
                {"float", 24'h0}:    t = 6'd7;
                {"for", 40'h0}:      t = 6'd8;
                {"if", 48'h0}:       t = 6'd9;
                {"int", 40'h0}:      t = 6'd10;
                {"return", 16'h0}:   t = 6'd11;
                {"string", 16'h0}:   t = 6'd12;
                {"true", 32'h0}:     t = 6'd13;
                {"void", 32'h0}:     t = 6'd14;
                {"while", 24'h0}:    t = 6'd15;
                default:             t = TYPE_IDENT;
            endcase
        end
        return t;
    endfunction

    // operator index, OP_NONE when the first len bytes form no operator
    function automatic logic [5:0] op_index(input logic [1:0] len, input logic [7:0] s0,
                                           input logic [7:0] s1, input logic [7:0] s2);
        logic [25:0] key;
        logic [5:0]  i;
        key = {len, s0, (len >= 2'd2) ? s1 : 8'h0, (len == 2'd3) ? s2 : 8'h0};
        case (key)
            {2'd1, "=", 16'h0}:  i = 6'd0;
            {2'd2, "*=", 8'h0}:  i = 6'd1;
            {2'd2, "/=", 8'h0}:  i = 6'd2;
            {2'd2, "%=", 8'h0}:  i = 6'd3;
            {2'd2, "+=", 8'h0}:  i = 6'd4;
            {2'd2, "-=", 8'h0}:  i = 6'd5;
            {2'd3, "<<="}:       i = 6'd6;
            {2'd3, ">>="}:       i = 6'd7;
            {2'd2, "&=", 8'h0}:  i = 6'd8;
            {2'd2, "|=", 8'h0}:  i = 6'd9;
            {2'd2, "^=", 8'h0}:  i = 6'd10;
            {2'd2, "&&", 8'h0}:  i = 6'd11;
            {2'd2, "||", 8'h0}:  i = 6'd12;
            {2'd1, "^", 16'h0}:  i = 6'd13;
            {2'd1, "&", 16'h0}:  i = 6'd14;
            {2'd1, "|", 16'h0}:  i = 6'd15;
            {2'd2, "==", 8'h0}:  i = 6'd16;
            {2'd2, "!=", 8'h0}:  i = 6'd17;
            {2'd1, ">", 16'h0}:  i = 6'd18;
            {2'd1, "<", 16'h0}:  i = 6'd19;
            {2'd2, ">=", 8'h0}:  i = 6'd20;
            {2'd2, "<=", 8'h0}:  i = 6'd21;
            {2'd2, ">>", 8'h0}:  i = 6'd22;
            {2'd2, "<<", 8'h0}:  i = 6'd23;
            {2'd1, "+", 16'h0}:  i = 6'd24;
            {2'd1, "-", 16'h0}:  i = 6'd25;
            {2'd1, "*", 16'h0}:  i = 6'd26;
            {2'd1, "/", 16'h0}:  i = 6'd27;
            {2'd1, "%", 16'h0}:  i = 6'd28;
            {2'd2, "++", 8'h0}:  i = 6'd29;
            {2'd2, "--", 8'h0}:  i = 6'd30;
            {2'd1, ",", 16'h0}:  i = 6'd31;
            {2'd1, ";", 16'h0}:  i = 6'd32;
            {2'd1, "!", 16'h0}:  i = 6'd33;
            {2'd1, "[", 16'h0}:  i = 6'd34;
            {2'd1, "]", 16'h0}:  i = 6'd35;
            {2'd1, "{", 16'h0}:  i = 6'd36;
            {2'd1, "}", 16'h0}:  i = 6'd37;
            {2'd1, "(", 16'h0}:  i = 6'd38;
            {2'd1, ")", 16'h0}:  i = 6'd39;
            default:             i = OP_NONE;
        endcase
        return i;
    endfunction

endpackage

FILE: rtl/core/cltok_lexer.sv
// Lexer state registers and the per-byte next-state and result logic.
// Produces up to three results for each accepted byte.
// Depends on cltok_pkg.
module cltok_lexer #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [7:0]                  in_byte,
    input  logic                        in_eot,
    output cltok_pkg::result_t [3:0]    res,
    output logic [2:0]                  res_count
);

    cltok_pkg::mode_t         mode_reg, mode_next;
    logic [7:0]               word_reg [8];
    logic [7:0]               word_next [8];
    logic [3:0]               wlen_reg, wlen_next;
    logic [7:0]               op_reg [3];
    logic [7:0]               op_next [3];
    logic [1:0]               olen_reg, olen_next;
    logic                     dot_reg, dot_next;
    logic                     esc_reg, esc_next;
    logic [LINE_BITS-1:0]     line_reg, line_next, sline_reg, sline_next, pl;
    logic [COLUMN_BITS-1:0]   col_reg, col_next, scol_reg, scol_next, pc;
    logic                     err_reg, err_next;
    logic [2:0]               n;
    logic                     do_begin;
    logic [5:0]               grow_idx;
    logic [63:0]              key_cur, key_nxt;
    logic                     b_digit, b_alpha, b_space;

    function automatic logic [15:0] clamp_line(input logic [LINE_BITS-1:0] v);
        logic [32:0] t;
        t = 33'(v);
        return (t > 33'h0FFFF) ? 16'hFFFF : t[15:0];
    endfunction

    function automatic logic [11:0] clamp_col(input logic [COLUMN_BITS-1:0] v);
        logic [32:0] t;
        t = 33'(v);
        return (t > 33'h00FFF) ? 12'hFFF : t[11:0];
    endfunction

    function automatic cltok_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] ch,
                                              input logic [5:0] ty, input logic [15:0] l,
                                              input logic [11:0] c, input logic [1:0] e);
        cltok_pkg::result_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.ttype = ty;
        r.line  = l;
        r.col   = c;
        r.ecode = e;
        r.last  = 1'b0;
        return r;
    endfunction

    assign b_digit = (in_byte >= "0") && (in_byte <= "9");
    assign b_alpha = ((in_byte >= "a") && (in_byte <= "z"))
                  || ((in_byte >= "A") && (in_byte <= "Z"));
    assign b_space = (in_byte == " ") || ((in_byte >= 8'd9) && (in_byte <= 8'd13));
    assign pl = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign pc = (col_reg == '1) ? col_reg : col_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key_cur[63-8*i -: 8] = (4'(i) < wlen_reg) ? word_reg[i] : 8'h0;
            key_nxt[63-8*i -: 8] = (4'(i) < wlen_next) ? word_next[i] : 8'h0;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        op_next    = op_reg;
        olen_next  = olen_reg;
        dot_next   = dot_reg;
        esc_next   = esc_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        err_next   = err_reg;
        n          = 3'd0;
        do_begin   = 1'b0;
        grow_idx   = cltok_pkg::OP_NONE;
        for (int i = 0; i < 4; i++)
        begin
            res[i] = '0;
        end

        if (in_fire && !err_reg)
        begin
            unique case (mode_reg)
                cltok_pkg::MODE_NUM_DIGIT, cltok_pkg::MODE_NUM_DOT:
                begin
                    if (b_digit)
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                        n = n + 3'd1;
                        mode_next = cltok_pkg::MODE_NUM_DIGIT;
                    end
                    else if (in_byte == ".")
                    begin
                        if (dot_reg)
                        begin
                            res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                                clamp_col(pc), (mode_reg == cltok_pkg::MODE_NUM_DOT)
                                ? cltok_pkg::ERR_BAD_END : cltok_pkg::ERR_DOT);
                            n = n + 3'd1;
                            err_next  = 1'b1;
                            mode_next = cltok_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            dot_next = 1'b1;
                            res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                            n = n + 3'd1;
                            mode_next = cltok_pkg::MODE_NUM_DOT;
                        end
                    end
                    else if (b_alpha || (mode_reg == cltok_pkg::MODE_NUM_DOT))
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                            clamp_col(pc), cltok_pkg::ERR_BAD_END);
                        n = n + 3'd1;
                        err_next  = 1'b1;
                        mode_next = cltok_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0,
                            dot_reg ? cltok_pkg::TYPE_FLOAT : cltok_pkg::TYPE_INT,
                            clamp_line(sline_reg), clamp_col(scol_reg), 2'd0);
                        n = n + 3'd1;
                        do_begin = 1'b1;
                    end
                end
                cltok_pkg::MODE_WORD:
                begin
                    if (b_alpha || b_digit || (in_byte == "_"))
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                        n = n + 3'd1;
                        if (wlen_reg < 4'd8)
                        begin
                            word_next[wlen_reg[2:0]] = in_byte;
                        end
                        if (wlen_reg < 4'd9)
                        begin
                            wlen_next = wlen_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0,
                            cltok_pkg::kw_type(key_cur, wlen_reg),
                            clamp_line(sline_reg), clamp_col(scol_reg), 2'd0);
                        n = n + 3'd1;
                        do_begin = 1'b1;
                    end
                end
                cltok_pkg::MODE_STRING:
                begin
                    if (esc_reg)
                    begin
                        if ((in_byte == 8'h0A) || (in_byte == 8'h00))
                        begin
                            res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                                clamp_col(pc), cltok_pkg::ERR_UNCLOSED);
                            n = n + 3'd1;
                            err_next  = 1'b1;
                            mode_next = cltok_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            esc_next = 1'b0;
                            res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                            n = n + 3'd1;
                        end
                    end
                    else if (in_byte == 8'h22)
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0, cltok_pkg::TYPE_STRING,
                            clamp_line(sline_reg), clamp_col(scol_reg), 2'd0);
                        n = n + 3'd1;
                        mode_next = cltok_pkg::MODE_IDLE;
                    end
                    else if ((in_byte == 8'h0A) || (in_byte == 8'h00))
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                            clamp_col(pc), cltok_pkg::ERR_UNCLOSED);
                        n = n + 3'd1;
                        err_next  = 1'b1;
                        mode_next = cltok_pkg::MODE_IDLE;
                    end
                    else if (in_byte == 8'h5C)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                        n = n + 3'd1;
                    end
                end
                cltok_pkg::MODE_OPER:
                begin
                    if ((olen_reg == 2'd1) || (olen_reg == 2'd2))
                    begin
                        grow_idx = cltok_pkg::op_index(olen_reg + 2'd1, op_reg[0],
                            (olen_reg == 2'd1) ? in_byte : op_reg[1], in_byte);
                    end
                    if (grow_idx != cltok_pkg::OP_NONE)
                    begin
                        op_next[olen_reg] = in_byte;
                        olen_next = olen_reg + 2'd1;
                    end
                    else
                    begin
                        grow_idx = cltok_pkg::op_index(olen_reg, op_reg[0], op_reg[1], op_reg[2]);
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0, cltok_pkg::TYPE_OP_BASE
                            + ((grow_idx != cltok_pkg::OP_NONE) ? grow_idx : 6'd0),
                            clamp_line(sline_reg), clamp_col(scol_reg), 2'd0);
                        n = n + 3'd1;
                        do_begin = 1'b1;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            if (do_begin)
            begin
                mode_next = cltok_pkg::MODE_IDLE;
                if (!b_space)
                begin
                    sline_next = pl;
                    scol_next  = pc;
                    if (b_digit)
                    begin
                        mode_next = cltok_pkg::MODE_NUM_DIGIT;
                        dot_next  = 1'b0;
                        res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                        n = n + 3'd1;
                    end
                    else if (b_alpha)
                    begin
                        mode_next    = cltok_pkg::MODE_WORD;
                        word_next[0] = in_byte;
                        wlen_next    = 4'd1;
                        res[n[1:0]] = mk(cltok_pkg::KIND_CHAR, in_byte, 6'd0, 16'd0, 12'd0, 2'd0);
                        n = n + 3'd1;
                    end
                    else if (in_byte == 8'h22)
                    begin
                        mode_next = cltok_pkg::MODE_STRING;
                        esc_next  = 1'b0;
                    end
                    else if (cltok_pkg::op_index(2'd1, in_byte, 8'h0, 8'h0) != cltok_pkg::OP_NONE)
                    begin
                        mode_next  = cltok_pkg::MODE_OPER;
                        op_next[0] = in_byte;
                        olen_next  = 2'd1;
                    end
                    else
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                            clamp_col(pc), cltok_pkg::ERR_UNKNOWN);
                        n = n + 3'd1;
                        err_next  = 1'b1;
                        mode_next = cltok_pkg::MODE_IDLE;
                    end
                end
            end

            if (in_byte == 8'h0A)
            begin
                line_next = pl;
                col_next  = '0;
            end
            else
            begin
                col_next = pc;
            end

            if (in_eot && !err_next)
            begin
                unique case (mode_next)
                    cltok_pkg::MODE_NUM_DIGIT:
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0,
                            dot_next ? cltok_pkg::TYPE_FLOAT : cltok_pkg::TYPE_INT,
                            clamp_line(sline_next), clamp_col(scol_next), 2'd0);
                        n = n + 3'd1;
                    end
                    cltok_pkg::MODE_NUM_DOT:
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                            clamp_col(pc), cltok_pkg::ERR_BAD_END);
                        n = n + 3'd1;
                        err_next = 1'b1;
                    end
                    cltok_pkg::MODE_WORD:
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0,
                            cltok_pkg::kw_type(key_nxt, wlen_next),
                            clamp_line(sline_next), clamp_col(scol_next), 2'd0);
                        n = n + 3'd1;
                    end
                    cltok_pkg::MODE_OPER:
                    begin
                        grow_idx = cltok_pkg::op_index(olen_next, op_next[0], op_next[1],
                            op_next[2]);
                        res[n[1:0]] = mk(cltok_pkg::KIND_TOKEN, 8'd0, cltok_pkg::TYPE_OP_BASE
                            + ((grow_idx != cltok_pkg::OP_NONE) ? grow_idx : 6'd0),
                            clamp_line(sline_next), clamp_col(scol_next), 2'd0);
                        n = n + 3'd1;
                    end
                    cltok_pkg::MODE_STRING:
                    begin
                        res[n[1:0]] = mk(cltok_pkg::KIND_ERROR, 8'd0, 6'd0, clamp_line(pl),
                            clamp_col(pc), cltok_pkg::ERR_UNCLOSED);
                        n = n + 3'd1;
                        err_next = 1'b1;
                    end
                    default:
                    begin
                        n = n;
                    end
                endcase
                mode_next = cltok_pkg::MODE_IDLE;
                wlen_next = 4'd0;
                olen_next = 2'd0;
                dot_next  = 1'b0;
                esc_next  = 1'b0;
                line_next = '0;
                col_next  = '0;
            end

            if (n != 3'd0)
            begin
                res[n[1:0] - 2'd1].last = 1'b1;
            end
        end
    end

    assign res_count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cltok_pkg::MODE_IDLE;
            wlen_reg  <= '0;
            olen_reg  <= '0;
            dot_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            line_reg  <= '0;
            col_reg   <= '0;
            sline_reg <= '0;
            scol_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            wlen_reg  <= wlen_next;
            olen_reg  <= olen_next;
            dot_reg   <= dot_next;
            esc_reg   <= esc_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        op_reg   <= op_next;
    end

endmodule

FILE: rtl/core/cltok_outq.sv
// Result register bank that holds the results of one byte and drains them in order.
// Accepts a fresh set while the final held result transfers.
// Depends on cltok_pkg.
module cltok_outq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  cltok_pkg::result_t [3:0]  load_res,
    input  logic [2:0]                load_count,
    output logic                      room,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cltok_pkg::result_t        out_res
);

    cltok_pkg::result_t [3:0] q_reg, q_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [1:0]               head_reg, head_next;
    logic                     pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ready);
    assign out_res   = q_reg[head_reg];

    always_comb
    begin
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (load)
        begin
            q_next    = load_res;
            cnt_next  = load_count;
            head_next = 2'd0;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 3'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            head_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result count out of range");
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> room)
        else $error("load while results still held");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (load_count != 3'd0)) |=> (out_valid && (head_reg == 2'd0)))
        else $error("loaded results not presented");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.last) |-> (cnt_reg == 3'd1))
        else $error("last marker not on final result");
`endif

endmodule

FILE: rtl/core/c_like_source_tokenizer_core.sv
// Top level of the streaming tokenizer for C-like source text.
// Instantiates cltok_lexer and cltok_outq; depends on cltok_pkg.
//
// Usage:
//   Slave stream: one source byte per transfer in s_tdata, s_tlast on the final
//   byte of a text. Master stream: one result per transfer, kind in m_tuser,
//   m_tlast on the last result caused by a byte.
//   A byte is processed in the cycle it transfers; its results (zero to three)
//   appear from the next cycle, one per cycle while the receiver accepts them.
//   Throughput: one byte per cycle while each byte gives at most one result and the
//   receiver is ready; a byte with more results holds off later bytes until the
//   single result port draining the result register bank reaches its final result.
//   A new byte is taken in the same cycle as the final held result transfers.
//   When the receiver stalls, held results stay and s_tready drops while the
//   bank holds any result.
//   After a lexical error one error result goes out and all later bytes are
//   taken and dropped until reset.
//   Reset clears the lexer state, line and column counters and the result bank.
module c_like_source_tokenizer_core #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // text_char, token_type, token_line, token_column,
                                   // error_code, zero fill
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last_result
);

    cltok_pkg::result_t [3:0] res;
    cltok_pkg::result_t       head;
    logic [2:0]               res_count;
    logic                     room;
    logic                     fire;

    assign s_tready = room;
    assign fire     = s_tvalid && room;

    cltok_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (fire),
        .in_byte   (s_tdata),
        .in_eot    (s_tlast),
        .res       (res),
        .res_count (res_count)
    );

    cltok_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_res   (res),
        .load_count (res_count),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (head)
    );

    assign m_tdata = {4'h0, head.ecode, head.col, head.line, head.ttype, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for c_like_source_tokenizer_core: streams source bytes in,
// predicts every character, token and error result, and compares them in order.
// Depends on cltok_pkg and the tokenizer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX   = 65535;
    localparam int COL_MAX    = 4095;
    localparam int LIMIT      = 3000000;
    localparam int TAIL_WAIT  = 20;
    localparam int HOLD_LONG  = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    c_like_source_tokenizer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    string keywords [16] = '{"bool", "break", "char", "continue", "do", "else", "false",
                             "float", "for", "if", "int", "return", "string", "true",
                             "void", "while"};
    string operators [40] = '{"=", "*=", "/=", "%=", "+=", "-=", "<<=", ">>=", "&=", "|=",
                              "^=", "&&", "||", "^", "&", "|", "==", "!=", ">", "<",
                              ">=", "<=", ">>", "<<", "+", "-", "*", "/", "%", "++",
                              "--", ",", ";", "!", "[", "]", "{", "}", "(", ")"};
    string gaps_ws [6] = '{" ", "\n", "\t", "\r", "\v", "\f"};

    logic [8:0]          src_bytes [$];
    cltok_pkg::result_t  lexed_results [$];
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  cycles = 0;

    // tokenizer state
    cltok_pkg::mode_t lx_mode = cltok_pkg::MODE_IDLE;
    logic [7:0] word_buf [8];
    int         word_len = 0;
    logic [7:0] op_buf [3];
    int         op_len = 0;
    bit         had_dot = 0;
    bit         esc_next = 0;
    int         line_n = 0;
    int         col_n = 0;
    int         tok_line = 0;
    int         tok_col = 0;
    bit         halted = 0;
    int         byte_results = 0;

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_let(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic int sat(int v, int max);
        return v >= max ? max : v + 1;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] ch, logic [5:0] ty,
                                       int ln, int cl, logic [1:0] ec);
        cltok_pkg::result_t r;
        if (byte_results >= 4)
            return;
        r.kind = kind;
        r.ch = ch;
        r.ttype = ty;
        r.line = ln[15:0];
        r.col = cl[11:0];
        r.ecode = ec;
        r.last = 1'b0;
        lexed_results.insert(lexed_results.size(), r);
        byte_results++;
    endfunction

    function automatic void raise_error(logic [1:0] code, int ln, int cl);
        add_result(cltok_pkg::KIND_ERROR, 8'h0, 6'd0, ln, cl, code);
        halted = 1;
        lx_mode = cltok_pkg::MODE_IDLE;
    endfunction

    function automatic int find_op(int len, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] s [3];
        bit hit;
        s[0] = a;
        s[1] = b;
        s[2] = c;
        for (int i = 0; i < 40; i++)
        begin
            if (operators[i].len() != len)
                continue;
            hit = 1;
            for (int k = 0; k < len; k++)
                if (operators[i][k] != s[k])
                    hit = 0;
            if (hit)
                return i;
        end
        return 40;
    endfunction

    function automatic void close_word();
        logic [5:0] ty;
        bit hit;
        ty = cltok_pkg::TYPE_IDENT;
        if (word_len <= 8)
            for (int i = 0; i < 16; i++)
            begin
                hit = keywords[i].len() == word_len;
                for (int k = 0; k < word_len && hit; k++)
                    if (keywords[i][k] != word_buf[k])
                        hit = 0;
                if (hit && ty == cltok_pkg::TYPE_IDENT)
                    ty = i[5:0];
            end
        add_result(cltok_pkg::KIND_TOKEN, 8'h0, ty, tok_line, tok_col, cltok_pkg::ERR_UNCLOSED);
        lx_mode = cltok_pkg::MODE_IDLE;
    endfunction

    function automatic void close_op();
        int idx;
        idx = find_op(op_len, op_buf[0], op_buf[1], op_buf[2]);
        add_result(cltok_pkg::KIND_TOKEN, 8'h0,
                   cltok_pkg::TYPE_OP_BASE + (idx < 40 ? idx[5:0] : 6'd0),
                   tok_line, tok_col, cltok_pkg::ERR_UNCLOSED);
        lx_mode = cltok_pkg::MODE_IDLE;
    endfunction

    function automatic void close_number();
        add_result(cltok_pkg::KIND_TOKEN, 8'h0,
                   had_dot ? cltok_pkg::TYPE_FLOAT : cltok_pkg::TYPE_INT, tok_line, tok_col,
                   cltok_pkg::ERR_UNCLOSED);
        lx_mode = cltok_pkg::MODE_IDLE;
    endfunction

    function automatic void open_token(logic [7:0] b, int pl, int pc);
        lx_mode = cltok_pkg::MODE_IDLE;
        if (is_ws(b))
            return;
        tok_line = pl;
        tok_col = pc;
        if (is_dig(b))
        begin
            lx_mode = cltok_pkg::MODE_NUM_DIGIT;
            had_dot = 0;
            add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0, cltok_pkg::ERR_UNCLOSED);
        end
        else if (is_let(b))
        begin
            lx_mode = cltok_pkg::MODE_WORD;
            word_buf[0] = b;
            word_len = 1;
            add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0, cltok_pkg::ERR_UNCLOSED);
        end
        else if (b == "\"")
        begin
            lx_mode = cltok_pkg::MODE_STRING;
            esc_next = 0;
        end
        else if (find_op(1, b, 8'h0, 8'h0) < 40)
        begin
            lx_mode = cltok_pkg::MODE_OPER;
            op_buf[0] = b;
            op_len = 1;
        end
        else
            raise_error(cltok_pkg::ERR_UNKNOWN, pl, pc);
    endfunction

    function automatic void lex_byte(logic [7:0] b, logic eot);
        int pl;
        int pc;
        byte_results = 0;
        if (halted)
            return;
        pl = sat(line_n, LINE_MAX);
        pc = sat(col_n, COL_MAX);
        case (lx_mode)
            cltok_pkg::MODE_NUM_DIGIT, cltok_pkg::MODE_NUM_DOT:
            begin
                if (is_dig(b))
                begin
                    add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0, cltok_pkg::ERR_UNCLOSED);
                    lx_mode = cltok_pkg::MODE_NUM_DIGIT;
                end
                else if (b == ".")
                begin
                    if (had_dot)
                        raise_error(lx_mode == cltok_pkg::MODE_NUM_DOT ? cltok_pkg::ERR_BAD_END
                                    : cltok_pkg::ERR_DOT, pl, pc);
                    else
                    begin
                        had_dot = 1;
                        add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0,
                                   cltok_pkg::ERR_UNCLOSED);
                        lx_mode = cltok_pkg::MODE_NUM_DOT;
                    end
                end
                else if (is_let(b) || lx_mode == cltok_pkg::MODE_NUM_DOT)
                    raise_error(cltok_pkg::ERR_BAD_END, pl, pc);
                else
                begin
                    close_number();
                    open_token(b, pl, pc);
                end
            end
            cltok_pkg::MODE_WORD:
            begin
                if (is_let(b) || is_dig(b) || b == "_")
                begin
                    add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0, cltok_pkg::ERR_UNCLOSED);
                    if (word_len < 8)
                        word_buf[word_len] = b;
                    if (word_len < 9)
                        word_len++;
                end
                else
                begin
                    close_word();
                    open_token(b, pl, pc);
                end
            end
            cltok_pkg::MODE_STRING:
            begin
                if (esc_next)
                begin
                    if (b == "\n" || b == 8'h0)
                        raise_error(cltok_pkg::ERR_UNCLOSED, pl, pc);
                    else
                    begin
                        esc_next = 0;
                        add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0,
                                   cltok_pkg::ERR_UNCLOSED);
                    end
                end
                else if (b == "\"")
                begin
                    add_result(cltok_pkg::KIND_TOKEN, 8'h0, cltok_pkg::TYPE_STRING, tok_line,
                               tok_col, cltok_pkg::ERR_UNCLOSED);
                    lx_mode = cltok_pkg::MODE_IDLE;
                end
                else if (b == "\n" || b == 8'h0)
                    raise_error(cltok_pkg::ERR_UNCLOSED, pl, pc);
                else if (b == "\\")
                    esc_next = 1;
                else
                    add_result(cltok_pkg::KIND_CHAR, b, 6'd0, 0, 0, cltok_pkg::ERR_UNCLOSED);
            end
            cltok_pkg::MODE_OPER:
            begin
                if (op_len < 3 && find_op(op_len + 1, op_buf[0], op_len == 1 ? b : op_buf[1],
                                          b) < 40)
                begin
                    op_buf[op_len] = b;
                    op_len++;
                end
                else
                begin
                    close_op();
                    open_token(b, pl, pc);
                end
            end
            default: open_token(b, pl, pc);
        endcase

        if (b == "\n")
        begin
            line_n = sat(line_n, LINE_MAX);
            col_n = 0;
        end
        else
            col_n = sat(col_n, COL_MAX);

        if (eot && !halted)
        begin
            case (lx_mode)
                cltok_pkg::MODE_NUM_DIGIT: close_number();
                cltok_pkg::MODE_NUM_DOT:   raise_error(cltok_pkg::ERR_BAD_END, pl, pc);
                cltok_pkg::MODE_WORD:      close_word();
                cltok_pkg::MODE_OPER:      close_op();
                cltok_pkg::MODE_STRING:    raise_error(cltok_pkg::ERR_UNCLOSED, pl, pc);
                default: ;
            endcase
            lx_mode = cltok_pkg::MODE_IDLE;
            word_len = 0;
            op_len = 0;
            had_dot = 0;
            esc_next = 0;
            line_n = 0;
            col_n = 0;
        end

        if (byte_results > 0)
            lexed_results[lexed_results.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(50, 200);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // source text helpers
    task automatic add(logic [7:0] b, logic last = 1'b0);
        src_bytes.insert(src_bytes.size(), {last, b});
    endtask

    task automatic add_str(string s, bit last = 0);
        for (int i = 0; i < s.len(); i++)
            add(s[i], last && i == s.len() - 1);
    endtask

    task automatic add_token(int kind);
        int n;
        logic [7:0] b;
        case (kind)
            0: add_str(keywords[$urandom_range(0, 15)]);
            1:
            begin
                n = $urandom_range(0, 11);
                b = $urandom_range(0, 1) ? $urandom_range("a", "z") : $urandom_range("A", "Z");
                add(b);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: add($urandom_range("0", "9"));
                        1: add("_");
                        2: add($urandom_range("A", "Z"));
                        default: add($urandom_range("a", "z"));
                    endcase
                end
            end
            2, 3:
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add($urandom_range("0", "9"));
                if (kind == 3)
                begin
                    add(".");
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        add($urandom_range("0", "9"));
                end
            end
            4:
            begin
                add("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        add("\\");
                        do b = $urandom_range(1, 255); while (b == "\n");
                        add(b);
                    end
                    else
                    begin
                        do b = $urandom_range(1, 255); while (b == "\n" || b == "\"" || b == "\\");
                        add(b);
                    end
                end
                add("\"");
            end
            default: add_str(operators[$urandom_range(0, 39)]);
        endcase
    endtask

    task automatic add_text(int ntok);
        int kind;
        for (int t = 0; t < ntok; t++)
        begin
            kind = $urandom_range(0, 5);
            add_token(kind);
            if (t == ntok - 1 && $urandom_range(0, 1))
            begin
                src_bytes[src_bytes.size() - 1][8] = 1'b1;
                return;
            end
            if (!(kind >= 4 && $urandom_range(0, 3) == 0))
                add_str(gaps_ws[$urandom_range(0, 5)], t == ntok - 1);
            else if (t == ntok - 1)
                add(" ", 1'b1);
        end
    endtask

    task automatic add_error_case();
        case ($urandom_range(0, 7))
            0: add_str("s = \"ab\ncd");
            1: add_str("\"ab\\\n");
            2: add_str("\"ab\\", 1);
            3: add_str("\"open", 1);
            4: add_str("x = 12.3.4");
            5: add_str("1..");
            6: add_str("3a");
            default:
            begin
                add_str("a ");
                case ($urandom_range(0, 3))
                    0: add($urandom_range(128, 255));
                    1: add(8'h0);
                    2: add(".");
                    default: add("_");
                endcase
            end
        endcase
        // dropped once the tokenizer has halted
        add_str("int y = 7; \"z\"", 1);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // source side
    int src_calm = 0;
    int src_idle = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                lex_byte(s_tdata, s_tlast);
                src_idle = pick_gap(src_calm);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_idle > 0)
                begin
                    src_idle--;
                    s_tvalid <= 1'b0;
                end
                else if (src_bytes.size() > 0)
                begin
                    item = src_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item[7:0];
                    s_tlast <= item[8];
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    int  long_left = 0;
    bit  held_long = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_left <= 0;
        else if (!held_long && results_seen >= 150)
        begin
            held_long <= 1'b1;
            long_left <= HOLD_LONG;
        end
        else if (long_left > 0)
            long_left <= long_left - 1;
    end

    // result side
    int  sink_calm = 0;
    int  sink_hold = 0;
    always @(posedge clk or negedge rst_n)
    begin
        cltok_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (lexed_results.size() == 0)
                    report_mismatch("unexpected result kind", m_tuser, 0);
                else
                begin
                    want = lexed_results.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("result_kind", m_tuser, want.kind);
                    if (m_tdata[7:0] != want.ch)
                        report_mismatch("text_char", m_tdata[7:0], want.ch);
                    if (m_tdata[13:8] != want.ttype)
                        report_mismatch("token_type", m_tdata[13:8], want.ttype);
                    if (m_tdata[29:14] != want.line)
                        report_mismatch("token_line", m_tdata[29:14], want.line);
                    if (m_tdata[41:30] != want.col)
                        report_mismatch("token_column", m_tdata[41:30], want.col);
                    if (m_tdata[43:42] != want.ecode)
                        report_mismatch("error_code", m_tdata[43:42], want.ecode);
                    if (m_tdata[47:44] != 4'h0)
                        report_mismatch("tdata fill", m_tdata[47:44], 0);
                    if (m_tlast != want.last)
                        report_mismatch("last_result", m_tlast, want.last);
                end
                results_seen++;
            end
            if (long_left > 0)
                m_tready <= 1'b0;
            else if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                sink_hold = pick_gap(sink_calm);
                m_tready <= (sink_hold == 0);
                if (sink_hold > 0)
                    sink_hold--;
            end
        end
    end

    initial
    begin
        add_str("while(x<<=3.25){s=\"a\\\"b\";}", 1);
        add_str("\"\" continue continuex1 bool _", 0);
        src_bytes.delete(src_bytes.size() - 1);
        add_str("7 9.5 Ab_9", 1);
        for (int i = 0; i < 40; i++)
            add_str({operators[i], " "});
        for (int i = 0; i < 16; i++)
            add_str({keywords[i], (i == 15) ? "" : " "}, i == 15);
        while (src_bytes.size() < 460)
            add_text($urandom_range(1, 12));
        add_error_case();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (src_bytes.size() > 0 || s_tvalid || lexed_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (lexed_results.size() > 0)
            report_mismatch("results never arrived", 0, lexed_results.size());
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cltok_pkg.sv
rtl/core/cltok_lexer.sv
rtl/core/cltok_outq.sv
rtl/core/c_like_source_tokenizer_core.sv
dv/tb_top.sv
